// ===== rtl/core/samsu_pkg.sv =====
// ----------------------------------------------------------------------------
// samsu_pkg
// Shared types, constants and pointer helpers for the three-stack unit.
// ----------------------------------------------------------------------------
package samsu_pkg;

	localparam int CAPACITY   = 16;
	localparam int NUM_STACKS = 3;
	localparam int DATA_WIDTH = 32;
	localparam int SEL_W      = 2;
	localparam int STAT_W     = 2;

	localparam int PTR_W  = $clog2(CAPACITY);
	localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int Slice  = CAPACITY / NUM_STACKS;

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [SIDX_W-1:0]     sidx_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [STAT_W-1:0]     stat_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam stat_t STAT_OK    = 2'd0;
	localparam stat_t STAT_UNDER = 2'd1;
	localparam stat_t STAT_OVER  = 2'd2;

	function automatic ptr_t ptr_next(input ptr_t p);
		return (p == ptr_t'(CAPACITY - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	function automatic ptr_t ptr_prev(input ptr_t p);
		return (p == '0) ? ptr_t'(CAPACITY - 1) : ptr_t'(p - 1'b1);
	endfunction

	// number of words between start and end, modulo the ring size
	function automatic ptr_t ptr_len(input ptr_t s, input ptr_t e);
		logic [PTR_W:0] wide;
		if (e >= s)
			wide = {1'b0, e} - {1'b0, s};
		else
			wide = {1'b0, e} + (PTR_W+1)'(CAPACITY) - {1'b0, s};
		return wide[PTR_W-1:0];
	endfunction

	function automatic sidx_t stk_next(input sidx_t k);
		return (k == sidx_t'(NUM_STACKS - 1)) ? '0 : sidx_t'(k + 1'b1);
	endfunction

	function automatic sidx_t stk_prev(input sidx_t k);
		return (k == '0) ? sidx_t'(NUM_STACKS - 1) : sidx_t'(k - 1'b1);
	endfunction

endpackage

// ===== rtl/core/samsu_ram.sv =====
// ----------------------------------------------------------------------------
// samsu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module samsu_ram #(
	parameter int Width = 32,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/shared_array_multi_stack_unit.sv =====
// ----------------------------------------------------------------------------
// shared_array_multi_stack_unit
// Several stacks kept in one circular data memory, shifting neighbours on push.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries op, stack_sel and push_value;
// output channel (out_valid / out_stall) returns pop_value and status, one
// result beat for every input beat, in order.
// A plain push, a pop, an underflow, an overflow or an out-of-range selector
// is handled by accepting the beat, writing or reading the memory, and then
// loading the result into the output register. No new input beat is taken
// until that result has been loaded.
// A push whose stack touches the next one first moves the chain of touching
// stacks up one slot, farthest first. Each moved stack is copied word by
// word through the single read and write port pair of the data memory
// (one word is read and one written per cycle).
// in_stall is high while an item is being worked on. When out_stall holds a
// result, the output register keeps it and the next result waits in the
// unit, which then takes no further input.
// Reset empties every stack, placing the stacks evenly round the ring; the
// data memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module shared_array_multi_stack_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [samsu_pkg::SEL_W-1:0] stack_sel,
	input  logic [samsu_pkg::DATA_WIDTH-1:0] push_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [samsu_pkg::DATA_WIDTH-1:0] pop_value,
	output logic [samsu_pkg::STAT_W-1:0] status
);
	import samsu_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SHIFT  = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0] state_q;
	ptr_t       start_q [NUM_STACKS];
	ptr_t       end_q   [NUM_STACKS];

	sidx_t s_q;
	sidx_t k_q;
	data_t value_q;
	ptr_t  cnt_q;
	ptr_t  src_q;
	logic  pend_s1;
	ptr_t  wdst_s1;
	logic  res_pop_q;
	stat_t res_status_q;

	logic  out_valid_q;
	data_t pop_value_q;
	stat_t status_q;

	logic  accept;
	logic  sel_ok;
	sidx_t sel_i;
	logic  [NUM_STACKS-1:0] touch;
	logic  chain_end;
	logic  over;
	sidx_t far;
	logic  empty;
	logic  shift_step_done;
	logic  last_stack;

	logic  ram_wr_en;
	ptr_t  ram_wr_addr;
	data_t ram_wr_data;
	logic  ram_rd_en;
	ptr_t  ram_rd_addr;
	data_t ram_rd_data;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;

	assign sel_ok = (stack_sel < NUM_STACKS);
	assign sel_i  = sel_ok ? sidx_t'(stack_sel) : '0;
	assign empty  = (start_q[sel_i] == end_q[sel_i]);

	// walk the chain of touching stacks starting at the addressed one
	always_comb begin
		for (int k = 0; k < NUM_STACKS; k++)
			touch[k] = (end_q[k] == start_q[stk_next(sidx_t'(k))]);
		far       = sel_i;
		chain_end = 1'b0;
		for (int i = 0; i < NUM_STACKS; i++) begin
			if (!chain_end) begin
				if (!touch[far])
					chain_end = 1'b1;
				else
					far = stk_next(far);
			end
		end
		over = !chain_end;
	end

	assign shift_step_done = (state_q == S_SHIFT) && (cnt_q == '0) && !pend_s1;
	assign last_stack      = (k_q == stk_next(s_q));

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = src_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = wdst_s1;
		ram_wr_data = ram_rd_data;
		if (accept && sel_ok) begin
			if (op == OP_POP) begin
				ram_rd_en   = !empty;
				ram_rd_addr = ptr_prev(end_q[sel_i]);
			end else if (!over && far == sel_i) begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = end_q[sel_i];
				ram_wr_data = push_value;
			end
		end
		if (state_q == S_SHIFT) begin
			ram_rd_en = (cnt_q != '0);
			if (pend_s1) begin
				ram_wr_en = 1'b1;
			end else if (shift_step_done && last_stack) begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = end_q[s_q];
				ram_wr_data = value_q;
			end
		end
	end

	samsu_ram #(
		.Width(DATA_WIDTH),
		.Depth(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			cnt_q       <= '0;
			for (int i = 0; i < NUM_STACKS; i++) begin
				start_q[i] <= ptr_t'(i * Slice);
				end_q[i]   <= ptr_t'(i * Slice);
			end
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						s_q          <= sel_i;
						value_q      <= push_value;
						res_pop_q    <= 1'b0;
						res_status_q <= STAT_OK;
						state_q      <= S_RESULT;
						if (sel_ok) begin
							if (op == OP_POP) begin
								if (empty) begin
									res_status_q <= STAT_UNDER;
								end else begin
									end_q[sel_i] <= ptr_prev(end_q[sel_i]);
									res_pop_q    <= 1'b1;
								end
							end else if (over) begin
								res_status_q <= STAT_OVER;
							end else if (far == sel_i) begin
								end_q[sel_i] <= ptr_next(end_q[sel_i]);
							end else begin
								k_q     <= far;
								cnt_q   <= ptr_len(start_q[far], end_q[far]);
								src_q   <= ptr_prev(end_q[far]);
								state_q <= S_SHIFT;
							end
						end
					end
				end
				S_SHIFT: begin
					pend_s1 <= (cnt_q != '0);
					if (cnt_q != '0) begin
						// word read now lands one slot higher next cycle
						wdst_s1 <= ptr_next(src_q);
						src_q   <= ptr_prev(src_q);
						cnt_q   <= cnt_q - 1'b1;
					end else if (!pend_s1) begin
						start_q[k_q] <= ptr_next(start_q[k_q]);
						end_q[k_q]   <= ptr_next(end_q[k_q]);
						if (last_stack) begin
							end_q[s_q] <= ptr_next(end_q[s_q]);
							state_q    <= S_RESULT;
						end else begin
							k_q   <= stk_prev(k_q);
							cnt_q <= ptr_len(start_q[stk_prev(k_q)], end_q[stk_prev(k_q)]);
							src_q <= ptr_prev(end_q[stk_prev(k_q)]);
						end
					end
				end
				S_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						pop_value_q <= res_pop_q ? ram_rd_data : '0;
						status_q    <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/samsu_checker.sv =====
// ----------------------------------------------------------------------------
// samsu_checker
// Port-level checks on the three-stack unit, bound to the top level.
// ----------------------------------------------------------------------------
module samsu_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [samsu_pkg::DATA_WIDTH-1:0] pop_value,
	input logic [samsu_pkg::STAT_W-1:0] status
);
	import samsu_pkg::*;

	// one item in flight: an accepted beat always blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken back to back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pop_value) && $stable(status))
		else $error("stalled result beat changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_UNDER || status == STAT_OVER))
		else $error("bad status code");

	// failed operations return no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> pop_value == '0)
		else $error("data on failed operation");

endmodule

bind shared_array_multi_stack_unit samsu_checker u_samsu_checker (.*);
